@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, also while reset is high.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every rising edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ hdl/rts_pkg.sv @@
`default_nettype none

package rts_pkg;

   localparam int SLOTS_DEFAULT     = 16;
   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 4;

   // At most this many fired reports are delivered for one tick.
   localparam int MAX_REPORTS = 16;

   // Width that holds any slot index and the slot count itself.
   localparam int IDX_EXT_W = 9;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_ADD    = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   localparam logic [2:0] ST_FIRED   = 3'd0;
   localparam logic [2:0] ST_ADDED   = 3'd1;
   localparam logic [2:0] ST_DELETED = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] period;
      logic [15:0] shots;
      logic [3:0]  handle;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic       last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_ADD,
      CMD_DELETE,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  period;
      logic [15:0]  shots;
      logic [3:0]   handle;
   } cmd_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] period;
      logic [15:0] remaining;
      logic [15:0] stamp;
   } slot_rec_type;

endpackage

`default_nettype wire

@@ hdl/repeating_timer_scheduler.sv @@
`default_nettype none

// Timer table of SLOTS entries on a tick-driven time base, seen as a request
// queue and a response queue: write a request with push while full is low,
// and take responses with pop while empty is low. An add request takes the
// lowest free slot and answers added with the slot, or table full; a delete
// answers deleted or unknown handle; a tick advances time by one and answers
// one fired response per due timer, most recently armed first, with last set
// on the final one (at most 16 responses per tick; the others are still
// processed). Requests of the unused code are taken and dropped. The request
// queue keeps accepting while earlier requests are being worked on, but the
// engine behind it handles one request at a time and walks the slot table
// one entry per cycle through a slot memory with one read port and one
// write port: an add walks to the first free slot, a tick walks the whole
// table, and a tick with several due timers makes a fresh pass over the
// table before each further fired timer, to pick the next youngest one.
// Responses wait in their own queue, so a slow consumer only stalls the
// engine once that queue has filled.
module repeating_timer_scheduler #(
   parameter int SLOTS     = rts_pkg::SLOTS_DEFAULT,
   parameter int CMD_DEPTH = rts_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = rts_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire rts_pkg::req_item_type req_item,
   output logic                       empty,
   input  wire logic                  pop,
   output rts_pkg::rsp_item_type      rsp_item
);

   localparam int RSPW = $bits(rts_pkg::rsp_item_type);

   // Classified requests between the front and the engine.
   logic             cmd_valid;
   rts_pkg::cmd_type cmd;
   logic             cmd_pop;

   // Responses from the engine into the response queue.
   logic                  eng_push;
   logic                  eng_full;
   rts_pkg::rsp_item_type eng_rsp;
   logic [RSPW-1:0]       rsp_rdata;

   // The front checks and normalizes each request and queues it.
   rts_front #(
      .SLOTS(SLOTS),
      .DEPTH(CMD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // The engine owns time, the arm counter and the slot table.
   rts_back #(
      .SLOTS(SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (eng_full),
      .rsp_push  (eng_push),
      .rsp_item  (eng_rsp)
   );

   // Responses leave in the order the engine produced them.
   rts_fifo #(
      .WIDTH(RSPW),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (eng_push),
      .wdata (eng_rsp),
      .full  (eng_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign rsp_item = rts_pkg::rsp_item_type'(rsp_rdata);

endmodule

`default_nettype wire

@@ hdl/rts_ram.sv @@
`default_nettype none

module rts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/rts_fifo.sv @@
`default_nettype none

module rts_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/rts_front.sv @@
`default_nettype none

module rts_front #(
   parameter int SLOTS = rts_pkg::SLOTS_DEFAULT,
   parameter int DEPTH = rts_pkg::CMD_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire rts_pkg::req_item_type req_item,
   output logic                      cmd_valid,
   output rts_pkg::cmd_type          cmd,
   input  wire logic                 cmd_pop
);

   localparam int CMDW = $bits(rts_pkg::cmd_type);

   rts_pkg::cmd_type  cls;
   logic              keep;
   logic [CMDW-1:0]   q_rdata;
   logic              q_empty;

   // Classify the request: normalize zero period and shot count, range check
   // the delete handle, and drop the unused request code.
   always_comb begin
      keep       = 1'b1;
      cls.period = (req_item.period == '0) ? 16'd1 : req_item.period;
      cls.shots  = (req_item.shots == '0) ? 16'd1 : req_item.shots;
      cls.handle = req_item.handle;
      unique case (req_item.req_type) inside
         rts_pkg::REQ_TICK: begin
            cls.kind = rts_pkg::CMD_TICK;
         end
         rts_pkg::REQ_ADD: begin
            cls.kind = rts_pkg::CMD_ADD;
         end
         rts_pkg::REQ_DELETE: begin
            if (rts_pkg::IDX_EXT_W'(req_item.handle) < rts_pkg::IDX_EXT_W'(SLOTS)) begin
               cls.kind = rts_pkg::CMD_DELETE;
            end else begin
               cls.kind = rts_pkg::CMD_REJECT;
            end
         end
         default: begin
            keep     = 1'b0;
            cls.kind = rts_pkg::CMD_TICK;
         end
      endcase
   end

   rts_fifo #(
      .WIDTH(CMDW),
      .DEPTH(DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push && keep),
      .wdata (cls),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = rts_pkg::cmd_type'(q_rdata);

endmodule

`default_nettype wire

@@ hdl/rts_back.sv @@
`default_nettype none

module rts_back #(
   parameter int SLOTS = rts_pkg::SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   input  wire rts_pkg::cmd_type      cmd,
   output logic                       cmd_pop,
   input  wire logic                  rsp_full,
   output logic                       rsp_push,
   output rts_pkg::rsp_item_type      rsp_item
);

   localparam int SW   = $clog2(SLOTS);
   localparam int LW   = $clog2(SLOTS + 1);
   localparam int RW   = $clog2(rts_pkg::MAX_REPORTS + 1);
   localparam int RECW = $bits(rts_pkg::slot_rec_type);
   localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FIRE,
      S_ADD,
      S_DELETE
   } state_type;

   state_type             state_ff, state_in;
   rts_pkg::cmd_type      cmd_ff, cmd_in;
   logic [SW-1:0]         idx_ff, idx_in;
   logic [31:0]           now_ff, now_in;
   logic [15:0]           arm_ff, arm_in;
   logic [15:0]           base_ff, base_in;
   logic [SLOTS-1:0]      used_ff, used_in;
   logic [SLOTS-1:0]      due_ff, due_in;
   logic                  first_ff, first_in;
   logic                  found_ff, found_in;
   logic [SW-1:0]         best_ff, best_in;
   logic [15:0]           best_age_ff, best_age_in;
   rts_pkg::slot_rec_type best_rec_ff, best_rec_in;
   logic [LW-1:0]         left_ff, left_in;
   logic [RW-1:0]         reports_ff, reports_in;

   logic                  ram_we;
   logic [SW-1:0]         ram_waddr;
   rts_pkg::slot_rec_type wr_rec;
   logic [RECW-1:0]       ram_rdata;
   rts_pkg::slot_rec_type rd_rec;

   logic [15:0]                   age;
   logic                          cand;
   logic [15:0]                   rem_next;
   logic                          fire_last;
   logic                          report;
   logic [rts_pkg::IDX_EXT_W-1:0] idx_ext, best_ext, hext;
   logic [SW-1:0]                 hidx;

   assign rd_rec   = rts_pkg::slot_rec_type'(ram_rdata);
   assign idx_ext  = rts_pkg::IDX_EXT_W'(idx_ff);
   assign best_ext = rts_pkg::IDX_EXT_W'(best_ff);
   assign hext     = rts_pkg::IDX_EXT_W'(cmd_ff.handle);
   assign hidx     = hext[SW-1:0];

   // Ages are taken against the arm count at the start of the tick, so the
   // order stays fixed while due timers are re-armed.
   assign age       = base_ff - rd_rec.stamp;
   assign cand      = first_ff ? (used_ff[idx_ff] && (rd_rec.deadline == now_ff))
                               : due_ff[idx_ff];
   assign rem_next  = best_rec_ff.remaining - 16'd1;
   assign report    = (reports_ff != RW'(rts_pkg::MAX_REPORTS));
   assign fire_last = (left_ff == LW'(1)) || (reports_ff == RW'(rts_pkg::MAX_REPORTS - 1));

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      now_in      = now_ff;
      arm_in      = arm_ff;
      base_in     = base_ff;
      used_in     = used_ff;
      due_in      = due_ff;
      first_in    = first_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_age_in = best_age_ff;
      best_rec_in = best_rec_ff;
      left_in     = left_ff;
      reports_in  = reports_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_item    = '0;
      ram_we      = 1'b0;
      ram_waddr   = idx_ff;
      wr_rec      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               idx_in  = '0;
               unique case (cmd.kind) inside
                  rts_pkg::CMD_TICK: begin
                     now_in     = now_ff + 32'd1;
                     base_in    = arm_ff;
                     first_in   = 1'b1;
                     found_in   = 1'b0;
                     left_in    = '0;
                     reports_in = '0;
                     due_in     = '0;
                     state_in   = S_SCAN;
                  end
                  rts_pkg::CMD_ADD: begin
                     state_in = S_ADD;
                  end
                  rts_pkg::CMD_DELETE, rts_pkg::CMD_REJECT: begin
                     state_in = S_DELETE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (cand) begin
               if (first_ff) begin
                  due_in[idx_ff] = 1'b1;
                  left_in        = left_ff + LW'(1);
               end
               // Strict compare: on equal ages the lower slot stays chosen.
               if (!found_ff || (age < best_age_ff)) begin
                  found_in    = 1'b1;
                  best_in     = idx_ff;
                  best_age_in = age;
                  best_rec_in = rd_rec;
               end
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = found_in ? S_FIRE : S_IDLE;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end

         S_FIRE: begin
            if (!report || !rsp_full) begin
               rsp_push         = report;
               rsp_item.status  = rts_pkg::ST_FIRED;
               rsp_item.slot    = best_ext[3:0];
               rsp_item.last    = fire_last;
               if (report) begin
                  reports_in = reports_ff + RW'(1);
               end
               if (rem_next != '0) begin
                  ram_we           = 1'b1;
                  ram_waddr        = best_ff;
                  wr_rec.deadline  = best_rec_ff.deadline + 32'(best_rec_ff.period);
                  wr_rec.period    = best_rec_ff.period;
                  wr_rec.remaining = rem_next;
                  wr_rec.stamp     = arm_ff;
                  arm_in           = arm_ff + 16'd1;
               end else begin
                  used_in[best_ff] = 1'b0;
               end
               due_in[best_ff] = 1'b0;
               left_in         = left_ff - LW'(1);
               first_in        = 1'b0;
               found_in        = 1'b0;
               idx_in          = '0;
               state_in        = (left_ff == LW'(1)) ? S_IDLE : S_SCAN;
            end
         end

         S_ADD: begin
            if (!used_ff[idx_ff]) begin
               if (!rsp_full) begin
                  rsp_push         = 1'b1;
                  rsp_item.status  = rts_pkg::ST_ADDED;
                  rsp_item.slot    = idx_ext[3:0];
                  rsp_item.last    = 1'b1;
                  used_in[idx_ff]  = 1'b1;
                  ram_we           = 1'b1;
                  ram_waddr        = idx_ff;
                  wr_rec.deadline  = now_ff + 32'(cmd_ff.period);
                  wr_rec.period    = cmd_ff.period;
                  wr_rec.remaining = cmd_ff.shots;
                  wr_rec.stamp     = arm_ff;
                  arm_in           = arm_ff + 16'd1;
                  idx_in           = '0;
                  state_in         = S_IDLE;
               end
            end else if (idx_ff == LAST_IDX) begin
               if (!rsp_full) begin
                  rsp_push        = 1'b1;
                  rsp_item.status = rts_pkg::ST_FULL;
                  rsp_item.slot   = 4'd0;
                  rsp_item.last   = 1'b1;
                  idx_in          = '0;
                  state_in        = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end

         S_DELETE: begin
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_item.slot = cmd_ff.handle;
               rsp_item.last = 1'b1;
               if ((cmd_ff.kind == rts_pkg::CMD_DELETE) && used_ff[hidx]) begin
                  used_in[hidx]   = 1'b0;
                  rsp_item.status = rts_pkg::ST_DELETED;
               end else begin
                  rsp_item.status = rts_pkg::ST_UNKNOWN;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      base_ff     <= base_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
      best_rec_ff <= best_rec_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         idx_ff     <= '0;
         now_ff     <= '0;
         arm_ff     <= '0;
         used_ff    <= '0;
         due_ff     <= '0;
         first_ff   <= 1'b0;
         found_ff   <= 1'b0;
         left_ff    <= '0;
         reports_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         now_ff     <= now_in;
         arm_ff     <= arm_in;
         used_ff    <= used_in;
         due_ff     <= due_in;
         first_ff   <= first_in;
         found_ff   <= found_in;
         left_ff    <= left_in;
         reports_ff <= reports_in;
      end
   end

   // The read address is the next scan index, so the registered read data
   // always belongs to the slot that idx_ff points at.
   rts_ram #(
      .WIDTH(RECW),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_rec),
      .raddr (idx_in),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

@@ hdl/rts_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module rts_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  full,
   input wire logic                  empty,
   input wire logic                  pop,
   input wire rts_pkg::rsp_item_type rsp_item
);

   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (empty && !full), "queues not clear after reset")

   `ASSERT_SYNC(a_rsp_holds, clock, reset, (!empty && !pop) |=> (!empty && $stable(rsp_item)), "waiting response changed")

   `ASSERT_SYNC(a_single_last, clock, reset, (!empty && (rsp_item.status != rts_pkg::ST_FIRED)) |-> rsp_item.last, "single response without last")

   `ASSERT_SYNC(a_full_slot, clock, reset, (!empty && (rsp_item.status == rts_pkg::ST_FULL)) |-> (rsp_item.slot == 4'd0), "table full response with nonzero slot")

endmodule

bind repeating_timer_scheduler rts_checker u_rts_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);

`default_nettype wire

@@ bench/tb_repeating_timer_scheduler.sv @@
`default_nettype none

// Self-checking bench for the repeating timer scheduler.
//
// Requests go in through the push/full queue port and responses come back
// through the empty/pop queue port. Every request that the scheduler accepts
// is also run through a timer table kept inside this bench. That table
// predicts the responses the request must produce, and those predictions wait
// in order until the scheduler hands responses out. A response that arrives
// with nothing waiting, or that differs in any field, is reported and counted.
//
// The run opens with a short table of hand-picked requests. It covers an empty
// tick, unknown handles, the unused request code, zero period and zero shots,
// the largest period and shot count, and a delete of a used slot. It then
// fills the table to the full status and makes all sixteen timers fire on one
// tick, so that the youngest-first report order is seen at its longest. After
// that, a few hundred random requests follow. Both ports idle in random bursts
// except near the end of the run.
module tb_repeating_timer_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMER_SLOTS = rts_pkg::SLOTS_DEFAULT;
   // The request code that the scheduler takes and then drops.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 364;
   // Requests at the tail of the random part that are sent without idling.
   localparam int CALM_REQUESTS = 60;
   // The wait at the end covers a tick with sixteen due timers, plus some margin.
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      rts_pkg::req_item_type req;
      int                    reps;
      bit                    typed;
      rts_pkg::rsp_item_type want;
   } directed_row_type;

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  push     = 1'b0;
   logic                  full;
   rts_pkg::req_item_type req_item = '0;
   logic                  empty;
   logic                  pop      = 1'b0;
   rts_pkg::rsp_item_type rsp_item;

   always #1 clock = ~clock;

   repeating_timer_scheduler i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   // The bench's own copy of the timer table. The per-slot arrays are only
   // read for slots that are marked live, just as in the scheduler.
   logic [31:0] clock_now;
   logic [15:0] arm_seq;
   logic        live       [TIMER_SLOTS];
   logic [31:0] due_at     [TIMER_SLOTS];
   logic [15:0] every      [TIMER_SLOTS];
   logic [15:0] shots_left [TIMER_SLOTS];
   logic [15:0] armed_at   [TIMER_SLOTS];

   rts_pkg::rsp_item_type predicted[$];
   rts_pkg::rsp_item_type awaited_rsp[$];
   directed_row_type      plan[$];

   int mismatch_count = 0;
   bit calm_tail      = 1'b0;
   int rsp_stall      = 0;

   function automatic rts_pkg::rsp_item_type make_rsp(logic [2:0] st, logic [3:0] sl,
                                                      logic la);
      rts_pkg::rsp_item_type r;
      r.status = st;
      r.slot   = sl;
      r.last   = la;
      return r;
   endfunction

   // Age since the last arming. The age is counted modulo 2^16, so it stays
   // correct after the arming counter wraps.
   function automatic logic [15:0] age_of_slot(int s);
      return arm_seq - armed_at[s];
   endfunction

   function automatic void rearm_slot(int s, logic [31:0] deadline);
      due_at[s]   = deadline;
      armed_at[s] = arm_seq;
      arm_seq     = arm_seq + 16'd1;
   endfunction

   // Applies one request to the bench's table and appends the responses it
   // causes to the predicted queue.
   function automatic void predict_request(rts_pkg::req_item_type r);
      int          due_list[TIMER_SLOTS];
      int          n;
      int          j;
      int          s;
      int          free_slot;
      logic [15:0] p;
      logic [15:0] sh;
      n         = 0;
      free_slot = -1;
      case (r.req_type)
         rts_pkg::REQ_TICK: begin
            clock_now = clock_now + 32'd1;
            // Collect the due timers, youngest first. The sort is stable,
            // so timers of equal age keep the lower slot first.
            for (int i = 0; i < TIMER_SLOTS; i++) begin
               if (live[i] && due_at[i] == clock_now) begin
                  j = n;
                  while (j > 0 && age_of_slot(due_list[j - 1]) > age_of_slot(i)) begin
                     due_list[j] = due_list[j - 1];
                     j--;
                  end
                  due_list[j] = i;
                  n++;
               end
            end
            // Every due timer is processed. Only the first MAX_REPORTS of
            // them are reported.
            for (int k = 0; k < n; k++) begin
               s = due_list[k];
               if (k < rts_pkg::MAX_REPORTS) begin
                  predicted.push_back(make_rsp(rts_pkg::ST_FIRED, s[3:0],
                                               (k == n - 1) ||
                                               (k == rts_pkg::MAX_REPORTS - 1)));
               end
               shots_left[s] = shots_left[s] - 16'd1;
               if (shots_left[s] != 16'd0) begin
                  rearm_slot(s, due_at[s] + {16'd0, every[s]});
               end else begin
                  live[s] = 1'b0;
               end
            end
         end
         rts_pkg::REQ_ADD: begin
            for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
               if (!live[i]) begin
                  free_slot = i;
               end
            end
            if (free_slot < 0) begin
               predicted.push_back(make_rsp(rts_pkg::ST_FULL, 4'd0, 1'b1));
            end else begin
               p  = (r.period == 16'd0) ? 16'd1 : r.period;
               sh = (r.shots == 16'd0) ? 16'd1 : r.shots;
               live[free_slot]       = 1'b1;
               every[free_slot]      = p;
               shots_left[free_slot] = sh;
               rearm_slot(free_slot, clock_now + {16'd0, p});
               predicted.push_back(make_rsp(rts_pkg::ST_ADDED, free_slot[3:0], 1'b1));
            end
         end
         rts_pkg::REQ_DELETE: begin
            if (live[r.handle]) begin
               live[r.handle] = 1'b0;
               predicted.push_back(make_rsp(rts_pkg::ST_DELETED, r.handle, 1'b1));
            end else begin
               predicted.push_back(make_rsp(rts_pkg::ST_UNKNOWN, r.handle, 1'b1));
            end
         end
         default: begin
            // The unused request code is accepted and then dropped.
         end
      endcase
   endfunction

   function automatic void plan_row(logic [1:0] t, logic [15:0] p, logic [15:0] sh,
                                    logic [3:0] h, int reps, bit typed,
                                    logic [2:0] st, logic [3:0] sl);
      directed_row_type row;
      row.req.req_type = t;
      row.req.period   = p;
      row.req.shots    = sh;
      row.req.handle   = h;
      row.reps         = reps;
      row.typed        = typed;
      row.want         = make_rsp(st, sl, 1'b1);
      plan.push_back(row);
   endfunction

   // Random adds are mostly short-period timers with a few shots, so
   // they fire often and free their slots again. A minority use long or
   // random periods and shot counts, which fill the table. Most deletes aim
   // at a live slot. The fields that a request type does not use stay random.
   function automatic rts_pkg::req_item_type make_random_request();
      rts_pkg::req_item_type r;
      int                    pick;
      int                    live_slots[$];
      r.period = 16'($urandom_range(0, 65535));
      r.shots  = 16'($urandom_range(0, 65535));
      r.handle = 4'($urandom_range(0, 15));
      pick     = $urandom_range(0, 99);
      if (pick < 45) begin
         r.req_type = rts_pkg::REQ_TICK;
      end else if (pick < 78) begin
         r.req_type = rts_pkg::REQ_ADD;
         pick       = $urandom_range(0, 9);
         if (pick < 7) begin
            r.period = 16'($urandom_range(1, 6));
         end else if (pick == 7) begin
            r.period = 16'd0;
         end
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            r.shots = 16'($urandom_range(0, 4));
         end else if (pick < 17) begin
            r.shots = 16'($urandom_range(5, 20));
         end
      end else if (pick < 95) begin
         r.req_type = rts_pkg::REQ_DELETE;
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (live[i]) begin
               live_slots.push_back(i);
            end
         end
         if (live_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
            r.handle = 4'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
         end
      end else begin
         r.req_type = REQ_UNUSED;
      end
      return r;
   endfunction

   // Sends one request and waits until the scheduler takes it. The predicted
   // responses are queued at the edge where the request is accepted. A row
   // with a hand-written response queues that response in place of the
   // predicted one, but the bench's table is updated in either case.
   task automatic send_request(rts_pkg::req_item_type r, bit typed,
                               rts_pkg::rsp_item_type want);
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (full);
      predicted.delete();
      predict_request(r);
      if (typed) begin
         awaited_rsp.push_back(want);
      end else begin
         foreach (predicted[i]) begin
            awaited_rsp.push_back(predicted[i]);
         end
      end
   endtask

   // Response side: checks each accepted response against the oldest
   // prediction, and pulls pop low in random bursts.
   always @(posedge clock) begin : rsp_side
      rts_pkg::rsp_item_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response with none expected: status %0d slot %0d last %0d",
                        $time, rsp_item.status, rsp_item.slot, rsp_item.last);
               mismatch_count++;
            end else begin
               want = awaited_rsp[0];
               awaited_rsp.delete(0);
               if (rsp_item.status !== want.status || rsp_item.slot !== want.slot ||
                   rsp_item.last !== want.last) begin
                  $display("%0t: expected status %0d slot %0d last %0d, got %0d %0d %0d",
                           $time, want.status, want.slot, want.last,
                           rsp_item.status, rsp_item.slot, rsp_item.last);
                  mismatch_count++;
               end
            end
         end
         if (rsp_stall > 0 && !calm_tail) begin
            rsp_stall = rsp_stall - 1;
            pop <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 9);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int                    sent;
      rts_pkg::req_item_type r;
      clock_now = '0;
      arm_seq   = '0;
      foreach (live[i]) begin
         live[i] = 1'b0;
      end

      // A tick on an empty table gives no response.
      plan_row(rts_pkg::REQ_TICK, 16'h0000, 16'h0000, 4'd0, 1, 1'b0,
               rts_pkg::ST_FIRED, 4'd0);
      plan_row(rts_pkg::REQ_DELETE, 16'h0000, 16'h0000, 4'd15, 1, 1'b1,
               rts_pkg::ST_UNKNOWN, 4'd15);
      plan_row(REQ_UNUSED, 16'h1234, 16'h5678, 4'd9, 1, 1'b0,
               rts_pkg::ST_FIRED, 4'd0);
      // A zero period and a zero shot count both act as one.
      // This timer is due on the next tick.
      plan_row(rts_pkg::REQ_ADD, 16'h0000, 16'h0000, 4'd0, 1, 1'b1,
               rts_pkg::ST_ADDED, 4'd0);
      plan_row(rts_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 4'd15, 1, 1'b1,
               rts_pkg::ST_ADDED, 4'd1);
      plan_row(rts_pkg::REQ_DELETE, 16'hFFFF, 16'hFFFF, 4'd1, 1, 1'b1,
               rts_pkg::ST_DELETED, 4'd1);
      plan_row(rts_pkg::REQ_DELETE, 16'h0000, 16'h0000, 4'd1, 1, 1'b1,
               rts_pkg::ST_UNKNOWN, 4'd1);
      // Fill slots 1 to 15 with timers that fall due together with slot 0.
      // One more add finds the table full.
      plan_row(rts_pkg::REQ_ADD, 16'h0001, 16'h0003, 4'd0, 15, 1'b0,
               rts_pkg::ST_FIRED, 4'd0);
      plan_row(rts_pkg::REQ_ADD, 16'h0005, 16'h0005, 4'd5, 1, 1'b1,
               rts_pkg::ST_FULL, 4'd0);
      // The first of these ticks fires all sixteen timers, youngest first.
      // The next two fire the fifteen that are re-armed.
      plan_row(rts_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 4'd15, 3, 1'b0,
               rts_pkg::ST_FIRED, 4'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (int k = 0; k < plan[i].reps; k++) begin
            send_request(plan[i].req, plan[i].typed, plan[i].want);
         end
      end

      // Requests of the unused code do not count toward the random total.
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         r = make_random_request();
         if (r.req_type != REQ_UNUSED) begin
            sent++;
         end
         if (sent >= RANDOM_REQUESTS - CALM_REQUESTS) begin
            calm_tail = 1'b1;
         end
         send_request(r, 1'b0, make_rsp(rts_pkg::ST_FIRED, 4'd0, 1'b0));
      end
      push <= 1'b0;

      // Drain the responses still expected. A final tick that fires nothing
      // may still be walking the table, so wait a while longer for any
      // response that should not appear.
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_repeating_timer_scheduler OK");
      end else begin
         $display("tb_repeating_timer_scheduler NOT OK");
      end
      $finish;
   end

   // A correct run takes well under a third of this time, even when every
   // tick fires all sixteen timers and both ports stall as much as they can.
   initial begin : watchdog
      #2_000_000;
      $display("tb_repeating_timer_scheduler NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
